// ===== hdl/rsq_pkg.sv =====
`timescale 1ns / 1ps

package rsq_pkg;

  // Event codes on the input channel
  typedef enum logic [1:0] {
    KIND_FADE_DONE = 2'd0,
    KIND_STATE_REQ = 2'd1,
    KIND_RESEND    = 2'd2,
    KIND_NONE      = 2'd3
  } rsq_kind_e;

  // Commands to the fade engine
  localparam logic CMD_STOP    = 1'b0;
  localparam logic CMD_PROGRAM = 1'b1;

  localparam int unsigned NUM_PATTERNS = 10;
  localparam int unsigned PAT_W        = 4;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned ADDR_W       = 6;
  localparam int unsigned ROM_W        = 16;
  localparam int unsigned DUR_W        = 16;

  localparam logic [ROM_W-1:0] FULL = 16'd7000;

  typedef struct packed {
    logic [ROM_W-1:0] red;
    logic [ROM_W-1:0] green;
    logic [ROM_W-1:0] blue;
    logic [ROM_W-1:0] fade;
    logic [ROM_W-1:0] hold;
    logic             wrap;
  } rsq_step_t;

  localparam rsq_step_t STEP_ZERO = '0;

  function automatic rsq_step_t rsq_mk(input logic [ROM_W-1:0] r, input logic [ROM_W-1:0] g,
                                       input logic [ROM_W-1:0] b, input logic [ROM_W-1:0] fade,
                                       input logic [ROM_W-1:0] hold, input logic wrap);
    rsq_step_t s;
    s.red   = r;
    s.green = g;
    s.blue  = b;
    s.fade  = fade;
    s.hold  = hold;
    s.wrap  = wrap;
    return s;
  endfunction

  // First ROM step of each pattern
  function automatic logic [ADDR_W-1:0] rsq_base(input logic [PAT_W-1:0] pat);
    logic [ADDR_W-1:0] b;
    unique case (pat)
      4'd0:    b = 6'd0;
      4'd1:    b = 6'd1;
      4'd2:    b = 6'd3;
      4'd3:    b = 6'd5;
      4'd4:    b = 6'd7;
      4'd5:    b = 6'd9;
      4'd6:    b = 6'd11;
      4'd7:    b = 6'd13;
      4'd8:    b = 6'd15;
      4'd9:    b = 6'd25;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  // Step ROM: 44 programmed entries, the rest read as zero
  function automatic rsq_step_t rsq_rom(input logic [ADDR_W-1:0] addr);
    rsq_step_t s;
    unique case (addr)
      // boot
      6'd0:  s = rsq_mk(FULL, FULL, FULL, 16'd0, 16'd60000, 1'b1);
      // wifi
      6'd1:  s = rsq_mk(16'd0, 16'd0, FULL, 16'd1200, 16'd0, 1'b0);
      6'd2:  s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd1200, 16'd0, 1'b1);
      // tcp
      6'd3:  s = rsq_mk(16'd0, FULL, FULL, 16'd400, 16'd100, 1'b0);
      6'd4:  s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd400, 16'd300, 1'b1);
      // mqtt stall
      6'd5:  s = rsq_mk(16'd3500, 16'd0, FULL, 16'd900, 16'd0, 1'b0);
      6'd6:  s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd900, 16'd0, 1'b1);
      // cal
      6'd7:  s = rsq_mk(FULL, 16'd5950, 16'd0, 16'd800, 16'd0, 1'b0);
      6'd8:  s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd800, 16'd0, 1'b1);
      // learn
      6'd9:  s = rsq_mk(FULL, 16'd0, FULL, 16'd600, 16'd0, 1'b0);
      6'd10: s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd600, 16'd0, 1'b1);
      // ok
      6'd11: s = rsq_mk(16'd0, FULL, 16'd0, 16'd0, 16'd80, 1'b0);
      6'd12: s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd2920, 1'b1);
      // warn
      6'd13: s = rsq_mk(FULL, 16'd2800, 16'd0, 16'd0, 16'd100, 1'b0);
      6'd14: s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 1'b1);
      // fault
      6'd15, 6'd17, 6'd19, 6'd21, 6'd23:
        s = rsq_mk(FULL, 16'd0, 16'd0, 16'd0, 16'd50, 1'b0);
      6'd16, 6'd18, 6'd20, 6'd22:
        s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd50, 1'b0);
      6'd24: s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 1'b1);
      // tripped
      6'd25, 6'd27, 6'd29, 6'd37, 6'd39, 6'd41:
        s = rsq_mk(FULL, 16'd0, 16'd4900, 16'd0, 16'd100, 1'b0);
      6'd31, 6'd33, 6'd35:
        s = rsq_mk(FULL, 16'd0, 16'd4900, 16'd0, 16'd400, 1'b0);
      6'd26, 6'd28, 6'd30, 6'd32, 6'd34, 6'd36, 6'd38, 6'd40, 6'd42:
        s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 1'b0);
      6'd43: s = rsq_mk(16'd0, 16'd0, 16'd0, 16'd0, 16'd2000, 1'b1);
      default: s = STEP_ZERO;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/rgb_led_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Results are queued in registers and leave one per cycle while out_stall_i is low.
// One event per cycle while in_stall_o is low; a pattern change yields two results.
// Each event does one step ROM lookup; a four-entry result queue decouples output stalls.
// Reset (async, active low): boot pattern, step 0, fade phase, result queue empty.
module rgb_led_pattern_sequencer_unit import rsq_pkg::*; #(
  parameter int unsigned DUTY_BITS = 13,
  parameter int unsigned ROM_STEPS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // event channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [3:0]           requested_pattern_i,
  // command channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 command_o,
  output logic [DUTY_BITS-1:0] red_duty_o,
  output logic [DUTY_BITS-1:0] green_duty_o,
  output logic [DUTY_BITS-1:0] blue_duty_o,
  output logic [DUR_W-1:0]     duration_ms_o,
  output logic                 last_o
);

  localparam int unsigned RES_W = 1 + 3 * DUTY_BITS + DUR_W + 1;

  // Sequencer state. cur_step_q mirrors the ROM entry at the current
  // pattern/step so a fade-done event needs only one ROM lookup.
  logic [PAT_W-1:0]  pattern_q, pattern_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              hold_q, hold_d;
  rsq_step_t         cur_step_q;

  logic              accept;
  rsq_kind_e         kind;
  logic              req_ok;
  logic [1:0]        push_cnt;
  logic [ADDR_W-1:0] rom_addr;
  rsq_step_t         next_step;
  logic [RES_W-1:0]  stop_res, prog_res, first_res, head_res;
  logic              fifo_full2;
  logic              fifo_valid;

  assign kind   = rsq_kind_e'(kind_i);
  assign accept = in_valid_i && !in_stall_o;
  assign req_ok = (requested_pattern_i < PAT_W'(NUM_PATTERNS))
               && (requested_pattern_i != pattern_q);

  // Next state and how many results this event produces
  always_comb begin
    pattern_d = pattern_q;
    step_d    = step_q;
    hold_d    = hold_q;
    push_cnt  = 2'd0;
    unique case (kind)
      KIND_FADE_DONE: begin
        // enter hold only from fade and only for a step that has a hold time
        if (!hold_q && (cur_step_q.hold != '0)) begin
          hold_d = 1'b1;
        end else begin
          hold_d = 1'b0;
          step_d = cur_step_q.wrap ? '0 : step_q + STEP_W'(1);
        end
        push_cnt = 2'd1;
      end
      KIND_STATE_REQ: begin
        if (req_ok) begin
          pattern_d = requested_pattern_i;
          step_d    = '0;
          hold_d    = 1'b0;
          push_cnt  = 2'd2;
        end
      end
      KIND_RESEND: begin
        push_cnt = 2'd1;
      end
      default: begin
        push_cnt = 2'd0;
      end
    endcase
    if (!accept) begin
      pattern_d = pattern_q;
      step_d    = step_q;
      hold_d    = hold_q;
      push_cnt  = 2'd0;
    end
  end

  // Single ROM lookup at the post-event position; entries past the ROM read as zero
  always_comb begin
    rom_addr = rsq_base(pattern_d) + {1'b0, step_d};
    if (int'(rom_addr) >= int'(ROM_STEPS)) begin
      next_step = STEP_ZERO;
    end else begin
      next_step = rsq_rom(rom_addr);
    end
  end

  // Pack results: {command, red, green, blue, duration, last}
  always_comb begin
    stop_res = {CMD_STOP, {(3 * DUTY_BITS + DUR_W){1'b0}}, 1'b0};
    prog_res = {CMD_PROGRAM,
                next_step.red[DUTY_BITS-1:0],
                next_step.green[DUTY_BITS-1:0],
                next_step.blue[DUTY_BITS-1:0],
                hold_d ? next_step.hold : next_step.fade,
                1'b1};
    // a pattern change leads with the stop command
    first_res = (push_cnt == 2'd2) ? stop_res : prog_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= '0;
      step_q     <= '0;
      hold_q     <= 1'b0;
      cur_step_q <= rsq_rom('0);
    end else if (accept) begin
      pattern_q  <= pattern_d;
      step_q     <= step_d;
      hold_q     <= hold_d;
      cur_step_q <= next_step;
    end
  end

  rsq_out_fifo #(
    .WIDTH(RES_W)
  ) u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .first_i    (first_res),
    .second_i   (prog_res),
    .pop_i      (!out_stall_i),
    .full2_o    (fifo_full2),
    .valid_o    (fifo_valid),
    .data_o     (head_res)
  );

  // Hold off events whenever two more results might not fit
  assign in_stall_o  = fifo_full2;
  assign out_valid_o = fifo_valid;
  assign {command_o, red_duty_o, green_duty_o, blue_duty_o, duration_ms_o, last_o} = head_res;

endmodule

// ===== hdl/rsq_out_fifo.sv =====
`timescale 1ns / 1ps

// Four-entry result queue; takes up to two results per cycle, gives one while pop_i is high.
module rsq_out_fifo import rsq_pkg::*; #(
  parameter int unsigned WIDTH = 57
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  logic [WIDTH-1:0] first_i,
  input  logic [WIDTH-1:0] second_i,
  input  logic             pop_i,
  output logic             full2_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic [1:0] wr_next;
  logic       do_pop;

  assign do_pop  = pop_i && (count_q != 3'd0);
  assign wr_next = wr_ptr_q + 2'd1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + push_cnt_i;
    rd_ptr_d = rd_ptr_q + {1'b0, do_pop};
    count_d  = count_q + {1'b0, push_cnt_i} - {2'b00, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= first_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_next] <= second_i;
    end
  end

  // Room for two more results only while at most two are queued
  assign full2_o = count_q > 3'd2;
  assign valid_o = count_q != 3'd0;
  assign data_o  = mem[rd_ptr_q];

endmodule
